### rtl/e2cal_pkg.sv
// Shared types, constants, microcode table and month lengths for the epoch-to-calendar unit.
`timescale 1ns / 1ps

package e2cal_pkg;

  localparam int PcW = 4;

  // The input is biased by a whole number of days so the first divide works on an unsigned
  // value: t + 2^31 + LoadBias equals t + 24856 days.
  localparam logic [32:0] LoadBias  = 33'd74752;
  localparam logic [15:0] DayOffset = 16'd346;   // quotient to days since 1901-01-01
  localparam logic [15:0] WdOffset  = 16'd5;     // quotient to weekday, Sunday is zero
  localparam logic [15:0] Days32Y   = 16'd11688;
  localparam logic [15:0] Days4Y    = 16'd1461;
  localparam logic [7:0]  FirstYear = 8'd1;      // 1901, counted from 1900
  localparam logic [7:0]  Years32   = 8'd32;
  localparam logic [7:0]  Years4    = 8'd4;
  localparam logic [3:0]  MonLast   = 4'd11;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD_T,
    OP_DIV,
    OP_LOAD_WD,
    OP_LOAD_HR,
    OP_LOAD_MIN,
    OP_SAVE_MS,
    OP_YR32,
    OP_YR4,
    OP_YR1,
    OP_SAVE_YD,
    OP_MON,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    DV_DAY,
    DV_WEEK,
    DV_HOUR,
    DV_MIN
  } dsel_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_IN_IDLE,
    C_GE32,
    C_GE4,
    C_GE1,
    C_MON_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e            op;
    dsel_e          dsel;
    cond_e          cond;
    logic [PcW-1:0] target;
  } uword_t;

  typedef struct packed {
    op_e   op;
    dsel_e dsel;
  } uop_t;

  typedef struct packed {
    logic in_valid;
    logic ge32;
    logic ge4;
    logic ge1;
    logic mon_more;
    logic out_busy;
  } stat_t;

  // Step addresses of the program.
  localparam logic [PcW-1:0] PcIdle    = 4'd0;
  localparam logic [PcW-1:0] PcDivDay  = 4'd1;
  localparam logic [PcW-1:0] PcLoadWd  = 4'd2;
  localparam logic [PcW-1:0] PcDivWeek = 4'd3;
  localparam logic [PcW-1:0] PcLoadHr  = 4'd4;
  localparam logic [PcW-1:0] PcDivHour = 4'd5;
  localparam logic [PcW-1:0] PcLoadMin = 4'd6;
  localparam logic [PcW-1:0] PcDivMin  = 4'd7;
  localparam logic [PcW-1:0] PcSaveMs  = 4'd8;
  localparam logic [PcW-1:0] PcYr32    = 4'd9;
  localparam logic [PcW-1:0] PcYr4     = 4'd10;
  localparam logic [PcW-1:0] PcYr1     = 4'd11;
  localparam logic [PcW-1:0] PcSaveYd  = 4'd12;
  localparam logic [PcW-1:0] PcMon     = 4'd13;
  localparam logic [PcW-1:0] PcEmit    = 4'd14;
  localparam logic [PcW-1:0] PcEnd     = 4'd15;

  // A step whose condition holds jumps to its target; otherwise it falls through.
  // A divide step multiplies by a reciprocal, and the step after it reads quotient and
  // remainder, so it carries the same divider select.
  function automatic uword_t ucode_rom(logic [PcW-1:0] pc);
    uword_t w;
    unique case (pc)
      PcIdle:    w = '{OP_LOAD_T,   DV_DAY,  C_IN_IDLE,  PcIdle};
      PcDivDay:  w = '{OP_DIV,      DV_DAY,  C_NEVER,    PcIdle};
      PcLoadWd:  w = '{OP_LOAD_WD,  DV_DAY,  C_NEVER,    PcIdle};
      PcDivWeek: w = '{OP_DIV,      DV_WEEK, C_NEVER,    PcIdle};
      PcLoadHr:  w = '{OP_LOAD_HR,  DV_WEEK, C_NEVER,    PcIdle};
      PcDivHour: w = '{OP_DIV,      DV_HOUR, C_NEVER,    PcIdle};
      PcLoadMin: w = '{OP_LOAD_MIN, DV_HOUR, C_NEVER,    PcIdle};
      PcDivMin:  w = '{OP_DIV,      DV_MIN,  C_NEVER,    PcIdle};
      PcSaveMs:  w = '{OP_SAVE_MS,  DV_MIN,  C_NEVER,    PcIdle};
      PcYr32:    w = '{OP_YR32,     DV_DAY,  C_GE32,     PcYr32};
      PcYr4:     w = '{OP_YR4,      DV_DAY,  C_GE4,      PcYr4};
      PcYr1:     w = '{OP_YR1,      DV_DAY,  C_GE1,      PcYr1};
      PcSaveYd:  w = '{OP_SAVE_YD,  DV_DAY,  C_NEVER,    PcIdle};
      PcMon:     w = '{OP_MON,      DV_DAY,  C_MON_MORE, PcMon};
      PcEmit:    w = '{OP_EMIT,     DV_DAY,  C_OUT_BUSY, PcEmit};
      PcEnd:     w = '{OP_NOP,      DV_DAY,  C_ALWAYS,   PcIdle};
      default:   w = '{OP_NOP,      DV_DAY,  C_ALWAYS,   PcIdle};
    endcase
    return w;
  endfunction

  // Reciprocals that give the exact floor quotient over each dividend's range. The day split
  // divides the seconds shifted right by seven bits by 675, since 86400 is 128 times 675.
  function automatic logic [26:0] recip(dsel_e sel);
    logic [26:0] m;
    unique case (sel)
      DV_DAY:  m = 27'd101806633;   // 2^36 / 675, dividend below 2^26
      DV_WEEK: m = 27'd74899;       // 2^19 / 7, dividend below 2^16
      DV_HOUR: m = 27'd149131;      // 2^29 / 3600, dividend below 2^17
      DV_MIN:  m = 27'd4370;        // 2^18 / 60, dividend below 2^12
      default: m = 27'd101806633;
    endcase
    return m;
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] mon, logic leap);
    logic [4:0] n;
    unique case (mon)
      4'd1:                      n = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

### rtl/epoch_seconds_to_utc_calendar_unit.sv
// Top level: converts signed epoch seconds into broken-down UTC calendar fields.
`timescale 1ns / 1ps

// A word is accepted in the idle step and runs through the program until its result is
// presented; the emit step waits while the previous result still waits at the output. After
// the emit step the end step returns to the idle step, where the next word can be taken. The
// day split, the weekday and the hour and minute split take two steps each: a multiply by a
// fixed reciprocal in one shared 26 by 27 bit multiplier, then a step that forms quotient and
// remainder. The year walk in 32-year, 4-year and one-year steps and the walk over the month
// lengths follow, one step per cycle, and how long they run depends on the date. The unit takes
// one word at a time; a new word is accepted once the previous one has moved into the output
// register, so the next conversion runs while that result waits to be taken.
module epoch_seconds_to_utc_calendar_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] epoch_seconds_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         second_o,
  output logic [5:0]         minute_o,
  output logic [4:0]         hour_o,
  output logic [4:0]         month_day_o,
  output logic [3:0]         month_o,
  output logic [7:0]         years_since_1900_o,
  output logic [2:0]         weekday_o,
  output logic [8:0]         year_day_o
);
  import e2cal_pkg::*;

  uop_t  uop;
  logic  take;
  stat_t stat;

  logic [32:0]     acc_q, acc_d;
  logic [51:0]     prod_q, prod_d;
  logic [15:0]     day_q, day_d;
  logic [16:0]     sod_q, sod_d;
  logic [7:0]      yr_q, yr_d;
  logic [3:0]      mon_q, mon_d;
  logic [5:0]      ss_q, ss_d, mm_q, mm_d;
  logic [4:0]      hh_q, hh_d;
  logic [2:0]      wd_q, wd_d;
  logic [8:0]      yday_q, yday_d;

  logic            out_valid_q, out_valid_d;
  logic [5:0]      second_q, second_d, minute_q, minute_d;
  logic [4:0]      hour_q, hour_d, mday_q, mday_d;
  logic [3:0]      month_q, month_d;
  logic [7:0]      year_q, year_d;
  logic [2:0]      wkd_q, wkd_d;
  logic [8:0]      ydo_q, ydo_d;

  logic [25:0]     dvd, back, rem;
  logic [26:0]     rcp;
  logic [15:0]     quo;
  logic            leap;
  logic [8:0]      ylen;
  logic [4:0]      mlen;

  e2cal_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .uop_o  (uop),
    .take_o (take)
  );

  // Reciprocal divide: quotient from the registered product, remainder by a constant multiply.
  always_comb begin
    rcp = recip(uop.dsel);
    unique case (uop.dsel)
      DV_DAY: begin
        dvd  = acc_q[32:7];
        quo  = prod_q[51:36];
        back = {10'b0, quo} * 26'd675;
      end
      DV_WEEK: begin
        dvd  = acc_q[25:0];
        quo  = prod_q[34:19];
        back = {10'b0, quo} * 26'd7;
      end
      DV_HOUR: begin
        dvd  = acc_q[25:0];
        quo  = prod_q[44:29];
        back = {10'b0, quo} * 26'd3600;
      end
      DV_MIN: begin
        dvd  = acc_q[25:0];
        quo  = prod_q[33:18];
        back = {10'b0, quo} * 26'd60;
      end
      default: begin
        dvd  = acc_q[32:7];
        quo  = prod_q[51:36];
        back = {10'b0, quo} * 26'd675;
      end
    endcase
    rem     = dvd - back;
    // Years here run from 1901 to 2038, so every multiple of four is a leap year.
    leap    = yr_q[1:0] == 2'b00;
    ylen    = leap ? 9'd366 : 9'd365;
    mlen    = month_len(mon_q, leap);
  end

  assign stat = '{
    in_valid: in_valid_i,
    ge32:     day_q >= Days32Y,
    ge4:      day_q >= Days4Y,
    ge1:      day_q >= {7'b0, ylen},
    mon_more: (mon_q < MonLast) && (day_q >= {11'b0, mlen}),
    out_busy: out_valid_q && out_stall_i
  };

  always_comb begin
    acc_d  = acc_q;
    prod_d = prod_q;
    day_d  = day_q;
    sod_d  = sod_q;
    yr_d   = yr_q;
    mon_d  = mon_q;
    ss_d   = ss_q;
    mm_d   = mm_q;
    hh_d   = hh_q;
    wd_d   = wd_q;
    yday_d = yday_q;

    second_d = second_q;
    minute_d = minute_q;
    hour_d   = hour_q;
    mday_d   = mday_q;
    month_d  = month_q;
    year_d   = year_q;
    wkd_d    = wkd_q;
    ydo_d    = ydo_q;

    out_valid_d = out_valid_q && out_stall_i;

    unique case (uop.op)
      OP_NOP: begin
      end
      OP_LOAD_T: begin
        // Flipping the sign bit adds 2^31; the bias brings the total to whole days.
        acc_d = {1'b0, epoch_seconds_i ^ 32'h8000_0000} + LoadBias;
      end
      OP_DIV: begin
        prod_d = {26'b0, dvd} * {25'b0, rcp};
      end
      OP_LOAD_WD: begin
        day_d = quo + DayOffset;
        sod_d = {rem[9:0], acc_q[6:0]};
        yr_d  = FirstYear;
        acc_d = {17'b0, quo + WdOffset};
      end
      OP_LOAD_HR: begin
        wd_d  = rem[2:0];
        acc_d = {16'b0, sod_q};
      end
      OP_LOAD_MIN: begin
        hh_d  = quo[4:0];
        acc_d = {7'b0, rem};
      end
      OP_SAVE_MS: begin
        mm_d = quo[5:0];
        ss_d = rem[5:0];
      end
      OP_YR32: begin
        if (take) begin
          day_d = day_q - Days32Y;
          yr_d  = yr_q + Years32;
        end
      end
      OP_YR4: begin
        if (take) begin
          day_d = day_q - Days4Y;
          yr_d  = yr_q + Years4;
        end
      end
      OP_YR1: begin
        if (take) begin
          day_d = day_q - {7'b0, ylen};
          yr_d  = yr_q + 1'b1;
        end
      end
      OP_SAVE_YD: begin
        yday_d = day_q[8:0];
        mon_d  = '0;
      end
      OP_MON: begin
        if (take) begin
          day_d = day_q - {11'b0, mlen};
          mon_d = mon_q + 1'b1;
        end
      end
      OP_EMIT: begin
        if (!take) begin
          second_d    = ss_q;
          minute_d    = mm_q;
          hour_d      = hh_q;
          mday_d      = day_q[4:0] + 1'b1;
          month_d     = mon_q;
          year_d      = yr_q;
          wkd_d       = wd_q;
          ydo_d       = yday_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    prod_q   <= prod_d;
    day_q    <= day_d;
    sod_q    <= sod_d;
    yr_q     <= yr_d;
    mon_q    <= mon_d;
    ss_q     <= ss_d;
    mm_q     <= mm_d;
    hh_q     <= hh_d;
    wd_q     <= wd_d;
    yday_q   <= yday_d;
    second_q <= second_d;
    minute_q <= minute_d;
    hour_q   <= hour_d;
    mday_q   <= mday_d;
    month_q  <= month_d;
    year_q   <= year_d;
    wkd_q    <= wkd_d;
    ydo_q    <= ydo_d;
  end

  assign in_stall_o         = uop.op != OP_LOAD_T;
  assign out_valid_o        = out_valid_q;
  assign second_o           = second_q;
  assign minute_o           = minute_q;
  assign hour_o             = hour_q;
  assign month_day_o        = mday_q;
  assign month_o            = month_q;
  assign years_since_1900_o = year_q;
  assign weekday_o          = wkd_q;
  assign year_day_o         = ydo_q;

endmodule

### rtl/e2cal_seq.sv
// Microcode sequencer: step counter, program table and conditional jump logic.
`timescale 1ns / 1ps

module e2cal_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  e2cal_pkg::stat_t   stat_i,
  output e2cal_pkg::uop_t    uop_o,
  output logic               take_o
);
  import e2cal_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  uword_t         word;
  logic           take;

  always_comb begin
    word = ucode_rom(pc_q);
    unique case (word.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_IN_IDLE:  take = !stat_i.in_valid;
      C_GE32:     take = stat_i.ge32;
      C_GE4:      take = stat_i.ge4;
      C_GE1:      take = stat_i.ge1;
      C_MON_MORE: take = stat_i.mon_more;
      C_OUT_BUSY: take = stat_i.out_busy;
      default:    take = 1'b0;
    endcase
    pc_d = take ? word.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign uop_o  = '{op: word.op, dsel: word.dsel};
  assign take_o = take;

endmodule

### rtl/e2cal_chk.sv
// Port-level checker for the epoch-to-calendar unit and its bind to the top level.
`timescale 1ns / 1ps

module e2cal_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [5:0]         second_o,
  input logic [5:0]         minute_o,
  input logic [4:0]         hour_o,
  input logic [4:0]         month_day_o,
  input logic [3:0]         month_o,
  input logic [7:0]         years_since_1900_o,
  input logic [2:0]         weekday_o,
  input logic [8:0]         year_day_o
);

  // A stalled result word keeps its fields.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(second_o) && $stable(minute_o)
      && $stable(hour_o) && $stable(month_day_o) && $stable(month_o)
      && $stable(years_since_1900_o) && $stable(weekday_o) && $stable(year_day_o))
    else $error("result word changed while stalled");

  // Every calendar field stays within its range.
  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> second_o < 6'd60 && minute_o < 6'd60 && hour_o < 5'd24
      && month_o < 4'd12 && month_day_o != 5'd0 && weekday_o < 3'd7
      && year_day_o < 9'd366 && years_since_1900_o != 8'd0 && years_since_1900_o < 8'd139)
    else $error("calendar field out of range");

  // In January the day of the year, counted from zero, is one less than the day of the month.
  a_january: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && month_o == 4'd0 |-> year_day_o == {4'b0, month_day_o} - 9'd1)
    else $error("January day of year does not match day of month");

  // An accepted word keeps the input side busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an accept");

  // A new result appears only while the input side is not taking words.
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_stall_o)
    else $error("result appeared while the input side was open");

endmodule

bind epoch_seconds_to_utc_calendar_unit e2cal_chk u_e2cal_chk (.*);
